>>> hw/rtl/sjl_pkg.sv
// Shared types, constants and helper functions of the seam jump limiter.
package sjl_pkg;

  // Field widths
  localparam int POS_W      = 24;
  localparam int RANK_W     = 8;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 16;
  localparam int TOL_W      = 24;
  localparam int BASE_W     = 15;
  localparam int WID_W      = POS_W + 1;
  localparam int FRAC_W     = 8;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 2;

  localparam int MAX_POINTS_DEF = 256;

  // Saturation limits
  localparam logic [TOL_W-1:0] TOL_MAX = {TOL_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Register reset values
  localparam logic [7:0]        START_IMAGE_RST    = 8'd2;
  localparam logic [BASE_W-1:0] MAX_JUMP_WIDTH_RST = 15'd50;
  localparam logic [BASE_W-1:0] MAX_JUMP_DIFF_RST  = 15'd50;
  localparam logic [BASE_W-1:0] TOL_ADD_ON_RST     = 15'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_IMAGE    = 2'd0,
    REG_MAX_JUMP_WIDTH = 2'd1,
    REG_MAX_JUMP_DIFF  = 2'd2,
    REG_TOL_ADD_ON     = 2'd3
  } reg_index_t;

  typedef enum logic {
    OP_POINT      = 1'b0,
    OP_SEAM_START = 1'b1
  } op_t;

  typedef struct packed {
    logic [7:0]        start_image;
    logic [BASE_W-1:0] max_jump_width;
    logic [BASE_W-1:0] max_jump_diff;
    logic [BASE_W-1:0] tol_add_on;
  } cfg_t;

  // Request held between the read stage and the decision stage
  typedef struct packed {
    op_t                      op;
    logic                     first;
    logic [IDX_W-1:0]         idx;
    logic signed [POS_W-1:0]  left;
    logic signed [POS_W-1:0]  right;
    logic [RANK_W-1:0]        rank;
    logic [WID_W-1:0]         cur_w;
  } item_t;

  // One stored pair, with its seam width kept alongside
  typedef struct packed {
    logic signed [POS_W-1:0] left;
    logic signed [POS_W-1:0] right;
    logic [RANK_W-1:0]       rank;
    logic [WID_W-1:0]        wid;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } wr_req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] left;
    logic signed [POS_W-1:0] right;
    logic [RANK_W-1:0]       rank;
    logic [CNT_W-1:0]        reject_count;
  } result_t;

  // |a - b| of two signed positions
  function automatic logic [WID_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
                                                logic signed [POS_W-1:0] b);
    logic signed [WID_W-1:0] d;
    d = WID_W'(a) - WID_W'(b);
    return d[WID_W-1] ? WID_W'(-d) : WID_W'(d);
  endfunction

  // |a - b| of two unsigned widths
  function automatic logic [WID_W-1:0] abs_wdiff(logic [WID_W-1:0] a,
                                                 logic [WID_W-1:0] b);
    logic [WID_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    return d[WID_W] ? WID_W'(-d) : WID_W'(d);
  endfunction

  // Tolerance plus add-on, saturating
  function automatic logic [TOL_W-1:0] sat_add_tol(logic [TOL_W-1:0] a,
                                                   logic [BASE_W-1:0] add_on);
    logic [TOL_W:0] s;
    s = {1'b0, a} + (TOL_W+1)'({add_on, {FRAC_W{1'b0}}});
    return s[TOL_W] ? TOL_MAX : s[TOL_W-1:0];
  endfunction

  // Base register in whole units to Q16.8
  function automatic logic [TOL_W-1:0] to_q(logic [BASE_W-1:0] v);
    return TOL_W'({v, {FRAC_W{1'b0}}});
  endfunction

endpackage

>>> hw/rtl/sjl_if.sv
// Channel interfaces of the seam jump limiter: seam point requests and results.
interface sjl_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic              first_of_image;
  logic [7:0]        point_index;
  logic signed [23:0] left_in;
  logic signed [23:0] right_in;
  logic [7:0]        left_rank;
  logic [7:0]        right_rank;

  modport source (output valid, op, first_of_image, point_index, left_in, right_in,
                  left_rank, right_rank, input ready);
  modport sink   (input valid, op, first_of_image, point_index, left_in, right_in,
                  left_rank, right_rank, output ready);
endinterface

interface sjl_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] left_out;
  logic signed [23:0] right_out;
  logic [7:0]         rank_out;
  logic [15:0]        reject_count;

  modport source (output valid, left_out, right_out, rank_out, reject_count, input ready);
  modport sink   (input valid, left_out, right_out, rank_out, reject_count, output ready);
endinterface

>>> hw/rtl/seam_jump_limiter_core.sv
// Top level of the seam jump limiter: configuration, read stage and result register.
// Takes one seam point or seam start per cycle, back to back, unless a stalled output
// holds back a point. A point is read from the per-index store on the edge that
// accepts it, then decided from the read stage and registered in the result register;
// a seam start gives no result. The rate is set by the store's single read and single
// write per point, with the previous point's write forwarded when both touch the same
// index. The result register lets a new point enter while a finished result still
// waits. Seam start clears the store's valid bits at once, with no clearing pass. The
// user must write registers only while the block is idle; this is not enforced.
module seam_jump_limiter_core #(
  parameter int MAX_POINTS = sjl_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sjl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sjl_pkg::CFG_DATA_W-1:0] cfg_data,
  sjl_in_if.sink                        seam_in,
  sjl_out_if.source                     seam_out
);
  import sjl_pkg::*;

  cfg_t     cfg;
  logic     a_valid;
  item_t    a_item;
  logic     b_fire;
  logic     in_take;
  entry_t   stored;
  result_t  result;
  wr_req_t  wr;
  logic     out_valid;
  result_t  out_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_image    <= START_IMAGE_RST;
      cfg.max_jump_width <= MAX_JUMP_WIDTH_RST;
      cfg.max_jump_diff  <= MAX_JUMP_DIFF_RST;
      cfg.tol_add_on     <= TOL_ADD_ON_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_IMAGE:    cfg.start_image    <= cfg_data[7:0];
        REG_MAX_JUMP_WIDTH: cfg.max_jump_width <= cfg_data;
        REG_MAX_JUMP_DIFF:  cfg.max_jump_diff  <= cfg_data;
        REG_TOL_ADD_ON:     cfg.tol_add_on     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: a seam start never waits on the result register
  assign b_fire        = a_valid && (a_item.op == OP_SEAM_START || !out_valid
                                     || seam_out.ready);
  assign seam_in.ready = !a_valid || b_fire;
  assign in_take       = seam_in.valid && seam_in.ready;

  // Read stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (b_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_item.op    <= op_t'(seam_in.op);
      a_item.first <= seam_in.first_of_image;
      a_item.idx   <= seam_in.point_index;
      a_item.left  <= seam_in.left_in;
      a_item.right <= seam_in.right_in;
      a_item.rank  <= (seam_in.left_rank < seam_in.right_rank) ? seam_in.left_rank
                                                                : seam_in.right_rank;
      a_item.cur_w <= abs_diff(seam_in.right_in, seam_in.left_in);
    end
  end

  sjl_store #(
    .MAX_POINTS (MAX_POINTS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_take),
    .rd_idx   (seam_in.point_index),
    .look_idx (a_item.idx),
    .clear    (b_fire && a_item.op == OP_SEAM_START),
    .wr       (wr),
    .rd_entry (stored)
  );

  sjl_judge #(
    .MAX_POINTS (MAX_POINTS)
  ) u_judge (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (b_fire),
    .item   (a_item),
    .stored (stored),
    .result (result),
    .wr     (wr)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire && a_item.op == OP_POINT) begin
      out_valid <= 1'b1;
    end else if (seam_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && a_item.op == OP_POINT) begin
      out_data <= result;
    end
  end

  assign seam_out.valid        = out_valid;
  assign seam_out.left_out     = out_data.left;
  assign seam_out.right_out    = out_data.right;
  assign seam_out.rank_out     = out_data.rank;
  assign seam_out.reject_count = out_data.reject_count;

endmodule

>>> hw/rtl/sjl_store.sv
// Per-index pair store: synchronous memory, valid bits and one-deep write forwarding.
module sjl_store #(
  parameter int MAX_POINTS = sjl_pkg::MAX_POINTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [sjl_pkg::IDX_W-1:0] rd_idx,
  input  logic [sjl_pkg::IDX_W-1:0] look_idx,
  input  logic                     clear,
  input  sjl_pkg::wr_req_t         wr,
  output sjl_pkg::entry_t          rd_entry
);
  import sjl_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  entry_t                mem [MAX_POINTS];
  entry_t                mem_q;
  logic [MAX_POINTS-1:0] entry_valid;
  logic                  fwd_valid;
  logic [IDX_W-1:0]      fwd_idx;
  entry_t                fwd_entry;

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[AW'(wr.idx)] <= wr.entry;
    end
    if (rd_en) begin
      mem_q <= mem[AW'(rd_idx)];
    end
  end

  // Valid bits, cleared at once on reset and seam start
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      entry_valid <= '0;
    end else if (wr.en) begin
      entry_valid[AW'(wr.idx)] <= 1'b1;
    end
  end

  // Last write, for a read issued on the same edge as that write
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fwd_valid <= 1'b0;
    end else if (wr.en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fwd_idx   <= wr.idx;
      fwd_entry <= wr.entry;
    end
  end

  // Never-written entries read as zero
  always_comb begin
    if (fwd_valid && fwd_idx == look_idx) begin
      rd_entry = fwd_entry;
    end else if (entry_valid[AW'(look_idx)]) begin
      rd_entry = mem_q;
    end else begin
      rd_entry = '0;
    end
  end

endmodule

>>> hw/rtl/sjl_judge.sv
// Decision stage: jump checks, tolerance and counter state, store write request.
module sjl_judge #(
  parameter int MAX_POINTS = sjl_pkg::MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  sjl_pkg::cfg_t    cfg,
  input  logic             fire,
  input  sjl_pkg::item_t   item,
  input  sjl_pkg::entry_t  stored,
  output sjl_pkg::result_t result,
  output sjl_pkg::wr_req_t wr
);
  import sjl_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [CNT_W-1:0] image_count, image_count_next;
  logic [TOL_W-1:0] tol_w, tol_w_next;
  logic [TOL_W-1:0] tol_d, tol_d_next;
  logic [CNT_W-1:0] rejections, rejections_next;
  logic [CW-1:0]    stored_count, stored_count_next;
  entry_t           last_entry;

  logic [CNT_W-1:0] ic_inc;
  logic             load;
  logic [TOL_W-1:0] tw_use, td_use;
  logic             active, use_mem, reject, in_range, keep;
  entry_t           ref_entry, out_entry;
  logic [WID_W-1:0] jump_l, jump_r, jump_w;
  logic [31:0]      idx_plus;

  // Image count step, and tolerance reload on the first point of the first image
  always_comb begin
    ic_inc = image_count;
    if (item.first && image_count != CNT_MAX) begin
      ic_inc = image_count + 1'b1;
    end
    load   = item.first && image_count == '0;
    tw_use = load ? to_q(cfg.max_jump_width) : tol_w;
    td_use = load ? to_q(cfg.max_jump_diff) : tol_d;
    active = (ic_inc >= CNT_W'(cfg.start_image)) && stored_count != '0;
  end

  // Reads past the stored count take the last entry
  assign use_mem   = {24'd0, item.idx} < 32'(stored_count);
  assign ref_entry = use_mem ? stored : last_entry;

  // Jump checks
  assign jump_l = abs_diff(ref_entry.left, item.left);
  assign jump_r = abs_diff(ref_entry.right, item.right);
  assign jump_w = abs_wdiff(ref_entry.wid, item.cur_w);
  assign reject = active && (jump_l > {1'b0, tw_use} || jump_r > {1'b0, tw_use}
                             || jump_w > {1'b0, td_use});

  // Output pair and what goes back to the store
  always_comb begin
    if (reject) begin
      out_entry = ref_entry;
    end else begin
      out_entry.left  = item.left;
      out_entry.right = item.right;
      out_entry.rank  = item.rank;
      out_entry.wid   = item.cur_w;
    end
    keep     = out_entry.rank != '0;
    in_range = {24'd0, item.idx} < 32'(MAX_POINTS);
    idx_plus = {24'd0, item.idx} + 32'd1;
  end

  assign wr.en    = fire && item.op == OP_POINT && keep && in_range;
  assign wr.idx   = item.idx;
  assign wr.entry = out_entry;

  // State update
  always_comb begin
    image_count_next  = image_count;
    tol_w_next        = tol_w;
    tol_d_next        = tol_d;
    rejections_next   = rejections;
    stored_count_next = stored_count;
    if (item.op == OP_SEAM_START) begin
      image_count_next  = '0;
      rejections_next   = '0;
      tol_w_next        = to_q(cfg.max_jump_width);
      tol_d_next        = to_q(cfg.max_jump_diff);
      stored_count_next = '0;
    end else begin
      tol_w_next = tw_use;
      tol_d_next = td_use;
      if (active) begin
        if (reject) begin
          tol_w_next = sat_add_tol(tw_use, cfg.tol_add_on);
          tol_d_next = sat_add_tol(td_use, cfg.tol_add_on);
          if (rejections != CNT_MAX) begin
            rejections_next = rejections + 1'b1;
          end
        end else begin
          tol_w_next = to_q(cfg.max_jump_width);
          tol_d_next = to_q(cfg.max_jump_diff);
        end
      end
      image_count_next = ic_inc;
      if (!keep && ic_inc != '0) begin
        image_count_next = ic_inc - 1'b1;
      end
      if (keep && in_range && idx_plus > 32'(stored_count)) begin
        stored_count_next = CW'(idx_plus);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_count  <= '0;
      tol_w        <= '0;
      tol_d        <= '0;
      rejections   <= '0;
      stored_count <= '0;
    end else if (fire) begin
      image_count  <= image_count_next;
      tol_w        <= tol_w_next;
      tol_d        <= tol_d_next;
      rejections   <= rejections_next;
      stored_count <= stored_count_next;
    end
  end

  // Copy of the entry at stored_count-1
  always_ff @(posedge clk) begin
    if (wr.en && idx_plus >= 32'(stored_count)) begin
      last_entry <= out_entry;
    end
  end

  assign result.left         = out_entry.left;
  assign result.right        = out_entry.right;
  assign result.rank         = out_entry.rank;
  assign result.reject_count = rejections_next;

endmodule

>>> hw/rtl/sjl_checker.sv
// Port-level assertions for the seam jump limiter, bound to the top level.
module sjl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] left_out,
  input logic [23:0] right_out,
  input logic [7:0]  rank_out,
  input logic [15:0] reject_count
);

  // A stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({left_out, right_out, rank_out, reject_count}))
    else $error("result payload changed while stalled");

  // An accepted seam start leaves the input ready whatever the output side does
  a_start_drain: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_op |=> in_ready)
    else $error("seam start blocked the input");

  // A fresh result follows a point that passed the read stage and result registers
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && !in_op, 2))
    else $error("result without a matching point");

endmodule

bind seam_jump_limiter_core sjl_checker u_sjl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (seam_in.valid),
  .in_ready     (seam_in.ready),
  .in_op        (seam_in.op),
  .out_valid    (seam_out.valid),
  .out_ready    (seam_out.ready),
  .left_out     (seam_out.left_out),
  .right_out    (seam_out.right_out),
  .rank_out     (seam_out.rank_out),
  .reject_count (seam_out.reject_count)
);
